// ===== rtl/fwug_pkg.sv =====
// Shared types, codes and constants for the flash write unit gatherer.
// No dependencies; used by the configuration block and the top level.
`default_nettype none

package fwug_pkg;

  // Largest program unit the gather buffer holds.
  localparam int unsigned MaxUnitBytes = 32;
  // Width of the program size, fill and byte index fields.
  localparam int unsigned UnitW = 6;
  localparam int unsigned AddrW = 32;
  localparam int unsigned EraseW = 25;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Register reset values.
  localparam logic [AddrW-1:0]  BaseReset    = 32'd0;
  localparam logic [AddrW-1:0]  RegionReset  = 32'd4096;
  localparam logic [EraseW-1:0] EraseReset   = 25'd4096;
  localparam logic [UnitW-1:0]  ProgReset    = 6'd8;
  localparam logic [7:0]        ErasedReset  = 8'hFF;

  typedef enum logic [2:0] {
    RegBase   = 3'd0,
    RegRegion = 3'd1,
    RegErase  = 3'd2,
    RegProg   = 3'd3,
    RegErased = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CmdBegin = 2'd0,
    CmdWrite = 2'd1,
    CmdEnd   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KindErase   = 2'd0,
    KindProgram = 2'd1,
    KindStatus  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatInvalid  = 2'd1,
    StatOverflow = 2'd2
  } stat_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] address;
    logic [7:0]       out_byte;
    stat_e            status_code;
    logic             flash_unlocked;
    logic             last_result;
  } out_req_t;

  typedef struct packed {
    logic [AddrW-1:0]  base_address;
    logic [AddrW-1:0]  region_size;
    logic [EraseW-1:0] erase_bytes;
    logic [UnitW-1:0]  prog_bytes;
    logic [7:0]        erased_value;
  } cfg_t;

  // Clamp the programmed unit size into 1 .. max_bytes.
  function automatic logic [UnitW-1:0] unit_size(logic [UnitW-1:0] ps,
                                                 logic [UnitW-1:0] max_bytes);
    logic [UnitW-1:0] r;
    r = ps;
    if (ps == '0) r = UnitW'(1);
    if (ps > max_bytes) r = max_bytes;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fwug_cfg.sv =====
// APB-style configuration registers of the flash write unit gatherer.
// Depends on fwug_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module fwug_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fwug_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [fwug_pkg::ApbDataW-1:0] pwdata,
  output logic      [fwug_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output fwug_pkg::cfg_t                     cfg_o
);

  fwug_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[fwug_pkg::ApbAddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        fwug_pkg::RegBase:   cfg_d.base_address = pwdata;
        fwug_pkg::RegRegion: cfg_d.region_size  = pwdata;
        fwug_pkg::RegErase:  cfg_d.erase_bytes  = pwdata[fwug_pkg::EraseW-1:0];
        fwug_pkg::RegProg:   cfg_d.prog_bytes   = pwdata[fwug_pkg::UnitW-1:0];
        fwug_pkg::RegErased: cfg_d.erased_value = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fwug_pkg::RegBase:   prdata = cfg_q.base_address;
      fwug_pkg::RegRegion: prdata = cfg_q.region_size;
      fwug_pkg::RegErase:  prdata = {7'd0, cfg_q.erase_bytes};
      fwug_pkg::RegProg:   prdata = {26'd0, cfg_q.prog_bytes};
      fwug_pkg::RegErased: prdata = {24'd0, cfg_q.erased_value};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address <= fwug_pkg::BaseReset;
      cfg_q.region_size  <= fwug_pkg::RegionReset;
      cfg_q.erase_bytes  <= fwug_pkg::EraseReset;
      cfg_q.prog_bytes   <= fwug_pkg::ProgReset;
      cfg_q.erased_value <= fwug_pkg::ErasedReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fwug_unit_buf.sv =====
// Program-unit gather buffer: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module fwug_unit_buf #(
  parameter int unsigned Depth = 32,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_addr_i,
  input  wire logic [7:0]      wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output logic      [7:0]      rd_data_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/flash_write_unit_gatherer_unit.sv =====
// Flash write unit gatherer: top level with the command sequencer.
// Depends on fwug_pkg, fwug_cfg and fwug_unit_buf.
// Sequencing: a request that completes no unit goes straight to the status state. A
//   request that programs a unit passes the offset, check, optional erase, program and
//   status states; the program state primes the gather buffer read, then sends one byte
//   per accepted output. An overrunning unit goes from the check to the status state.
// Reset: asynchronous, active low; session closed, flash locked, no request pending.
`default_nettype none

module flash_write_unit_gatherer_unit #(
  parameter int unsigned MaxUnitBytes = fwug_pkg::MaxUnitBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire fwug_pkg::in_req_t             in_data_i,
  // result request channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output fwug_pkg::out_req_t                 out_data_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fwug_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [fwug_pkg::ApbDataW-1:0] pwdata,
  output logic      [fwug_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);

  localparam int unsigned IdxW = (MaxUnitBytes > 1) ? $clog2(MaxUnitBytes) : 1;
  localparam int unsigned UW   = fwug_pkg::UnitW;
  localparam int unsigned AW   = fwug_pkg::AddrW;

  // Sequencer states: take a request, form the unit offset, check it
  // against region and erase mark, then emit erase, program bytes, status.
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StOffs   = 6'b000010,
    StCheck  = 6'b000100,
    StErase  = 6'b001000,
    StProg   = 6'b010000,
    StStatus = 6'b100000
  } state_e;

  fwug_pkg::cfg_t cfg;

  fwug_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Control state.
  state_e          state_q, state_d;
  logic            open_q, open_d;
  logic            unlocked_q, unlocked_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [UW-1:0]   fill_q, fill_d;
  logic [AW:0]     nexte_q, nexte_d;
  fwug_pkg::stat_e sticky_q, sticky_d;
  logic            end_q, end_d;
  logic            rdv_q, rdv_d;
  logic [UW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  // Payload registers.
  fwug_pkg::stat_e    status_q, status_d;
  logic [UW-1:0]      sub_q, sub_d;
  logic [UW-1:0]      pad_q, pad_d;
  logic [AW-1:0]      offset_q, offset_d;
  logic [AW-1:0]      baddr_q, baddr_d;
  fwug_pkg::out_req_t out_data_q, out_data_d;

  // Gather buffer ports.
  logic            wr_en, rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      rd_data;

  logic [UW-1:0] ps;
  logic [UW-1:0] fill_inc;
  logic [UW-1:0] idx_inc;
  logic          out_load;
  logic [AW:0]   unit_end;

  assign ps       = fwug_pkg::unit_size(cfg.prog_bytes, UW'(MaxUnitBytes));
  assign fill_inc = fill_q + UW'(1);
  assign idx_inc  = idx_q + UW'(1);
  assign unit_end = {1'b0, offset_q} + {{(AW + 1 - UW){1'b0}}, ps};

  fwug_unit_buf #(
    .Depth (MaxUnitBytes)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q[IdxW-1:0]),
    .wr_data_i (in_data_i.data_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Take a new request only between requests; results leave through the
  // output register, and a waiting result holds the sequencer, blocking the input side.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  // The output register can take a result when empty or being drained.
  assign out_load    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    unlocked_d  = unlocked_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    nexte_d     = nexte_q;
    sticky_d    = sticky_q;
    end_d       = end_q;
    rdv_d       = rdv_q;
    idx_d       = idx_q;
    status_d    = status_q;
    sub_d       = sub_q;
    pad_d       = pad_q;
    offset_d    = offset_q;
    baddr_d     = baddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          end_d   = 1'b0;
          state_d = StStatus;
          case (in_data_i.command)
            fwug_pkg::CmdBegin: begin
              if (open_q) begin
                status_d = fwug_pkg::StatInvalid;
              end else begin
                // Open a session: unlock and clear the session state.
                open_d     = 1'b1;
                unlocked_d = 1'b1;
                pos_d      = '0;
                fill_d     = '0;
                nexte_d    = '0;
                sticky_d   = fwug_pkg::StatOk;
                status_d   = fwug_pkg::StatOk;
              end
            end
            fwug_pkg::CmdWrite: begin
              if (!open_q) begin
                status_d = fwug_pkg::StatInvalid;
              end else if (sticky_q != fwug_pkg::StatOk) begin
                // Drop the byte after an error; report the error again.
                status_d = sticky_q;
              end else begin
                // Gather the byte; a full unit goes on to the region check.
                wr_en    = (fill_q < UW'(MaxUnitBytes));
                fill_d   = fill_inc;
                pos_d    = pos_q + AW'(1);
                pad_d    = fill_inc;
                sub_d    = ps;
                status_d = fwug_pkg::StatOk;
                if (fill_inc >= ps) state_d = StOffs;
              end
            end
            fwug_pkg::CmdEnd: begin
              if (!open_q) begin
                status_d = fwug_pkg::StatInvalid;
              end else begin
                // Close after the status; a partial unit is padded and
                // programmed first, bytes at or past the fill read as erased.
                end_d    = 1'b1;
                status_d = sticky_q;
                if (sticky_q == fwug_pkg::StatOk && fill_q != '0) begin
                  sub_d   = fill_q;
                  pad_d   = fill_q;
                  state_d = StOffs;
                end
              end
            end
            default: status_d = fwug_pkg::StatInvalid;
          endcase
        end
      end

      StOffs: begin
        // Unit offset: the current position less the unit's byte count.
        offset_d = pos_q - {{(AW - UW){1'b0}}, sub_q};
        state_d  = StCheck;
      end

      StCheck: begin
        if (unit_end > {1'b0, cfg.region_size}) begin
          // Overrun: leave the unit unprogrammed and keep the fill.
          sticky_d = fwug_pkg::StatOverflow;
          status_d = fwug_pkg::StatOverflow;
          state_d  = StStatus;
        end else begin
          fill_d   = '0;
          status_d = fwug_pkg::StatOk;
          baddr_d  = cfg.base_address + offset_q;
          idx_d    = '0;
          rdv_d    = 1'b0;
          if (cfg.erase_bytes != '0 && {1'b0, offset_q} >= nexte_q) begin
            state_d = StErase;
          end else begin
            state_d = StProg;
          end
        end
      end

      StErase: begin
        if (out_load) begin
          out_valid_d                = 1'b1;
          out_data_d.kind            = fwug_pkg::KindErase;
          out_data_d.address         = cfg.base_address + nexte_q[AW-1:0];
          out_data_d.out_byte        = '0;
          out_data_d.status_code     = fwug_pkg::StatOk;
          out_data_d.flash_unlocked  = unlocked_q;
          out_data_d.last_result     = 1'b0;
          // Advance the erase mark past this erase unit.
          nexte_d = nexte_q + {{(AW + 1 - fwug_pkg::EraseW){1'b0}}, cfg.erase_bytes};
          state_d = StProg;
        end
      end

      StProg: begin
        if (!rdv_q) begin
          // Prime the buffer read for the first byte.
          rd_en = 1'b1;
          rdv_d = 1'b1;
        end else if (out_load) begin
          out_valid_d               = 1'b1;
          out_data_d.kind           = fwug_pkg::KindProgram;
          out_data_d.address        = baddr_q;
          out_data_d.out_byte       = (idx_q < pad_q) ? rd_data : cfg.erased_value;
          out_data_d.status_code    = fwug_pkg::StatOk;
          out_data_d.flash_unlocked = unlocked_q;
          out_data_d.last_result    = 1'b0;
          baddr_d                   = baddr_q + AW'(1);
          if (idx_q == ps - UW'(1)) begin
            rdv_d   = 1'b0;
            state_d = StStatus;
          end else begin
            // Fetch the next byte while this one goes out.
            idx_d   = idx_inc;
            rd_en   = 1'b1;
            rd_addr = idx_inc[IdxW-1:0];
          end
        end
      end

      StStatus: begin
        if (out_load) begin
          out_valid_d               = 1'b1;
          out_data_d.kind           = fwug_pkg::KindStatus;
          out_data_d.address        = '0;
          out_data_d.out_byte       = '0;
          out_data_d.status_code    = status_q;
          out_data_d.flash_unlocked = end_q ? 1'b0 : unlocked_q;
          out_data_d.last_result    = 1'b1;
          if (end_q) begin
            // Lock the flash as the closing status goes out.
            open_d     = 1'b0;
            unlocked_d = 1'b0;
          end
          end_d   = 1'b0;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      open_q      <= 1'b0;
      unlocked_q  <= 1'b0;
      pos_q       <= '0;
      fill_q      <= '0;
      nexte_q     <= '0;
      sticky_q    <= fwug_pkg::StatOk;
      end_q       <= 1'b0;
      rdv_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      unlocked_q  <= unlocked_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      nexte_q     <= nexte_d;
      sticky_q    <= sticky_d;
      end_q       <= end_d;
      rdv_q       <= rdv_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    sub_q      <= sub_d;
    pad_q      <= pad_d;
    offset_q   <= offset_d;
    baddr_q    <= baddr_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
